>>> rtl/nsng_pkg.sv
// ----------------------------------------------------------------------------
// nsng_pkg: shared types and codes for the next-smaller-of-next-greater unit
// Holds the stack command bundle and the compare mode codes that the
// sequencer, the compare unit and the index stack all use.
// ----------------------------------------------------------------------------
package nsng_pkg;

  // Command bundle from the sequencer to the index stack.
  // Clear wins over push, and push wins over pop.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stack_cmd_t;

  // Selects which strict relation the shared compare unit tests.
  typedef logic cmp_mode_t;

  localparam cmp_mode_t CMP_GT = 1'b0;  // a > b, used while loading
  localparam cmp_mode_t CMP_LT = 1'b1;  // a < b, used in the smaller pass

endpackage

>>> rtl/nsng_cmp.sv
// ----------------------------------------------------------------------------
// nsng_cmp: shared signed compare unit
// One signed two's complement compare that serves both stack passes; the mode
// picks strictly-greater or strictly-less.
// ----------------------------------------------------------------------------
module nsng_cmp #(
  parameter int DATA_WIDTH = 16
) (
  input  nsng_pkg::cmp_mode_t     mode,
  input  logic [DATA_WIDTH-1:0]   a,
  input  logic [DATA_WIDTH-1:0]   b,
  output logic                    hit
);
  import nsng_pkg::*;

  logic a_lt_b;

  // Both operands are two's complement.
  assign a_lt_b = $signed(a) < $signed(b);

  // Strictly greater is neither less nor equal.
  always_comb begin
    case (mode)
      CMP_LT:  hit = a_lt_b;
      default: hit = !a_lt_b && (a != b);
    endcase
  end

endmodule

>>> rtl/nsng_stack.sv
// ----------------------------------------------------------------------------
// nsng_stack: monotonic index stack
// Holds position and value pairs. The top entry lives in registers; the
// entries below it sit in a memory with a registered read, so a pop or a
// push can be issued in every cycle.
// ----------------------------------------------------------------------------
module nsng_stack #(
  parameter int MAX_LEN    = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  nsng_pkg::stack_cmd_t         cmd,
  input  logic [$clog2(MAX_LEN)-1:0]   push_idx,
  input  logic [DATA_WIDTH-1:0]        push_val,
  output logic [$clog2(MAX_LEN)-1:0]   top_idx,
  output logic [DATA_WIDTH-1:0]        top_val,
  output logic                         empty
);
  import nsng_pkg::*;

  localparam int IW   = $clog2(MAX_LEN);
  localparam int DEPW = $clog2(MAX_LEN + 1);
  localparam int EW   = IW + DATA_WIDTH;

  logic [EW-1:0]   mem [MAX_LEN];
  logic [EW-1:0]   top_q;
  logic [EW-1:0]   rd_q;
  logic [EW-1:0]   cur_top;
  logic [DEPW-1:0] depth;
  logic [DEPW-1:0] wr_ptr;
  logic [DEPW-1:0] rd_ptr;
  logic            pend;

  // After a pop the new top is still in the read register.
  assign cur_top = pend ? rd_q : top_q;
  assign top_idx = cur_top[EW-1:DATA_WIDTH];
  assign top_val = cur_top[DATA_WIDTH-1:0];
  assign empty   = (depth == '0);

  // The old top moves down to slot depth-1; a pop fetches slot depth-2.
  assign wr_ptr = depth - DEPW'(1);
  assign rd_ptr = depth - DEPW'(2);

  // Depth and pending-read control.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      pend  <= 1'b0;
    end else if (cmd.clear) begin
      depth <= '0;
      pend  <= 1'b0;
    end else if (cmd.push) begin
      depth <= depth + DEPW'(1);
      pend  <= 1'b0;
    end else if (cmd.pop) begin
      depth <= depth - DEPW'(1);
      pend  <= 1'b1;
    end else begin
      pend  <= 1'b0;
    end
  end

  // Stack memory, top register and registered read.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (depth != '0) begin
        mem[wr_ptr[IW-1:0]] <= cur_top;
      end
      top_q <= {push_idx, push_val};
    end else if (cmd.pop) begin
      rd_q <= mem[rd_ptr[IW-1:0]];
    end else if (pend) begin
      top_q <= rd_q;
    end
  end

endmodule

>>> rtl/next_smaller_of_next_greater_unit.sv
// Loading compares each element with the stack top, popping entries until it
// is pushed; each element is popped at most once, and a new element is taken
// only after the previous one has been pushed. The last element starts a
// second stack pass, then each result is fetched and held until the output
// side takes it. One shared compare unit sets the pace.
// Reset (rst, synchronous) empties the sequence and stack; memories keep data.
// ----------------------------------------------------------------------------
// next_smaller_of_next_greater_unit: next smaller of next greater element
// Loads a signed sequence, resolves each position's next greater element
// while loading, finds each next smaller value after the last element, and
// then streams one result per stored position.
// ----------------------------------------------------------------------------
module next_smaller_of_next_greater_unit #(
  parameter int MAX_LEN    = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input requests.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // sample_value
  input  logic                                  s_axis_tlast,  // is_last
  // Result requests.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,  // result_value
  output logic [1:0]                            m_axis_tuser,  // result_found, overflowed
  output logic                                  m_axis_tlast   // result_last
);
  import nsng_pkg::*;

  localparam int IW   = $clog2(MAX_LEN);
  localparam int DEPW = $clog2(MAX_LEN + 1);
  localparam int TDW  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int GW   = IW + 1;           // {has_greater, index}
  localparam int SW   = DATA_WIDTH + 1;   // {found, value}

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GLOAD = 3'd1;
  localparam logic [2:0] S_SRD   = 3'd2;
  localparam logic [2:0] S_SCMP  = 3'd3;
  localparam logic [2:0] S_ORD1  = 3'd4;
  localparam logic [2:0] S_ORD2  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]            state;
  logic [DEPW-1:0]       count;
  logic [DEPW-1:0]       pos;
  logic [DEPW-1:0]       count_m1;
  logic                  ovf;
  logic                  last_q;
  logic [DATA_WIDTH-1:0] cur_val;

  logic [DATA_WIDTH-1:0] elem_mem [MAX_LEN];
  logic [GW-1:0]         gi_mem   [MAX_LEN];
  logic [SW-1:0]         sm_mem   [MAX_LEN];
  logic [DATA_WIDTH-1:0] elem_q;
  logic [GW-1:0]         gi_q;
  logic [SW-1:0]         sm_q;

  logic                  in_fire;
  logic                  out_fire;
  logic                  room;
  logic                  in_pass;
  logic                  pop_go;
  logic                  push_go;
  logic                  go_smaller;
  logic                  finish;
  logic                  is_final;
  logic                  found;

  cmp_mode_t             cmp_mode;
  logic [DATA_WIDTH-1:0] cmp_a;
  logic                  cmp_hit;

  stack_cmd_t            stk_cmd;
  logic [IW-1:0]         push_idx;
  logic [IW-1:0]         top_idx;
  logic [DATA_WIDTH-1:0] top_val;
  logic                  stk_empty;

  // Handshakes and position bookkeeping.
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == S_OUT);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign room          = (count < DEPW'(MAX_LEN));
  assign count_m1      = count - DEPW'(1);
  assign is_final      = (pos == count_m1);

  // Shared compare: loading tests greater, the smaller pass tests less.
  assign in_pass  = (state == S_GLOAD) || (state == S_SCMP);
  assign cmp_mode = (state == S_SCMP) ? CMP_LT : CMP_GT;
  assign cmp_a    = (state == S_SCMP) ? elem_q : cur_val;

  nsng_cmp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_cmp (
    .mode(cmp_mode),
    .a   (cmp_a),
    .b   (top_val),
    .hit (cmp_hit)
  );

  // Pop while the top loses to the current element, otherwise push it.
  assign pop_go     = in_pass && !stk_empty && cmp_hit;
  assign push_go    = in_pass && !pop_go;
  assign go_smaller = (in_fire && !room && s_axis_tlast) ||
                      ((state == S_GLOAD) && push_go && last_q);
  assign finish     = out_fire && is_final;
  assign push_idx   = (state == S_SCMP) ? pos[IW-1:0] : count[IW-1:0];

  always_comb begin
    stk_cmd.clear = go_smaller || finish;
    stk_cmd.push  = push_go;
    stk_cmd.pop   = pop_go;
  end

  nsng_stack #(
    .MAX_LEN   (MAX_LEN),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .cmd     (stk_cmd),
    .push_idx(push_idx),
    .push_val(cmp_a),
    .top_idx (top_idx),
    .top_val (top_val),
    .empty   (stk_empty)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pos   <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (room) begin
              state <= S_GLOAD;
            end else begin
              ovf <= 1'b1;
              if (s_axis_tlast) begin
                pos   <= '0;
                state <= S_SRD;
              end
            end
          end
        end
        S_GLOAD: begin
          if (push_go) begin
            count <= count + DEPW'(1);
            if (last_q) begin
              pos   <= '0;
              state <= S_SRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SRD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (push_go) begin
            if (is_final) begin
              pos   <= '0;
              state <= S_ORD1;
            end else begin
              pos   <= pos + DEPW'(1);
              state <= S_SRD;
            end
          end
        end
        S_ORD1: begin
          state <= S_ORD2;
        end
        S_ORD2: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            if (is_final) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              pos   <= pos + DEPW'(1);
              state <= S_ORD1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Captured request fields.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_val <= s_axis_tdata[DATA_WIDTH-1:0];
      last_q  <= s_axis_tlast;
    end
  end

  // Element store: written on load, read once per position in the smaller pass.
  always_ff @(posedge clk) begin
    if (in_fire && room) begin
      elem_mem[count[IW-1:0]] <= s_axis_tdata[DATA_WIDTH-1:0];
    end
    if (state == S_SRD) begin
      elem_q <= elem_mem[pos[IW-1:0]];
    end
  end

  // Next-greater table: a popped entry learns its greater, a pushed one starts empty.
  always_ff @(posedge clk) begin
    if ((state == S_GLOAD) && pop_go) begin
      gi_mem[top_idx] <= {1'b1, count[IW-1:0]};
    end else if ((state == S_GLOAD) && push_go) begin
      gi_mem[count[IW-1:0]] <= {1'b0, count[IW-1:0]};
    end
    if (state == S_ORD1) begin
      gi_q <= gi_mem[pos[IW-1:0]];
    end
  end

  // Next-smaller table, filled the same way in the second pass.
  always_ff @(posedge clk) begin
    if ((state == S_SCMP) && pop_go) begin
      sm_mem[top_idx] <= {1'b1, elem_q};
    end else if ((state == S_SCMP) && push_go) begin
      sm_mem[pos[IW-1:0]] <= {1'b0, elem_q};
    end
    if (state == S_ORD2) begin
      sm_q <= sm_mem[gi_q[IW-1:0]];
    end
  end

  // Result formatting; a missing element reads as minus one.
  assign found        = gi_q[GW-1] && sm_q[SW-1];
  assign m_axis_tdata = TDW'(found ? sm_q[DATA_WIDTH-1:0] : {DATA_WIDTH{1'b1}});
  assign m_axis_tuser = {ovf, found};
  assign m_axis_tlast = is_final;

`ifndef SYNTHESIS
  // The stack never gets a push and a pop in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    !(stk_cmd.push && stk_cmd.pop))
    else $error("stack push and pop issued together");

  // The stored count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst)
    count <= DEPW'(MAX_LEN))
    else $error("element count beyond capacity");

  // Results only exist for a nonempty stored sequence.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (count != '0))
    else $error("result presented with no stored elements");

  // Taking the final result returns the block to an empty idle state.
  assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_axis_tlast) |=> (s_axis_tready && (count == '0) && !ovf))
    else $error("block not cleared after final result");

  // Input and output sides never both active.
  assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a result is pending");
`endif

endmodule
